FILE: hw/rtl/tfn_pkg.sv
package tfn_pkg;

  // default coordinate width, signed with 8 fraction bits
  localparam int unsigned COORD_WIDTH_DEF      = 16;
  // default fraction bits of each normal component
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;

endpackage

FILE: hw/rtl/triangle_face_normal.sv
// channel  | ports                                   | direction | width
// ---------+-----------------------------------------+-----------+-----------------------
// in       | in_valid, in_stall, in_corner_{a,b,c}_* | sink      | COORD_WIDTH each
// out      | out_valid, out_stall, out_unit_*        | source    | NORMAL_FRAC_BITS+2 each
//          | out_degenerate                          | source    | 1
//
// one item per cycle while out_stall is low
// the pipeline depth grows with the quotient pipeline, one stage per bit of the result
// every stage holds its own valid bit; a stalled output freezes only the stages
// that are full behind it, empty stages keep filling
// rst_n clears the valid bits only; payload registers are not reset

module triangle_face_normal #(
  parameter int unsigned COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_a_x,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_a_y,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_a_z,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_b_x,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_b_y,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_b_z,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_c_x,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_c_y,
  input  logic signed [COORD_WIDTH-1:0]      in_corner_c_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_unit_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_unit_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_unit_z,
  output logic                               out_degenerate
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned DFW = CW + 1;          // edge vector component
  localparam int unsigned PW  = 2 * DFW;         // one cross term
  localparam int unsigned NW  = PW + 1;          // cross product component
  localparam int unsigned MW  = NW;              // its magnitude
  localparam int unsigned HL  = MW / 2;          // low half for the split square
  localparam int unsigned HH  = MW - HL;
  localparam int unsigned SQW = 2 * MW;          // squared magnitude
  localparam int unsigned SW  = SQW + 2;         // sum of three squares
  localparam int unsigned DW  = SW + 2 * F + 3;  // remainder and trial terms
  localparam int unsigned QW  = F + 1;           // quotient magnitude
  localparam int unsigned OW  = F + 2;           // output component

  // stage numbering along the valid chain
  localparam int unsigned ST_DIF = 0;
  localparam int unsigned ST_MUL = 1;
  localparam int unsigned ST_CRS = 2;
  localparam int unsigned ST_PP  = 3;
  localparam int unsigned ST_SQ  = 4;
  localparam int unsigned ST_IT0 = 5;
  localparam int unsigned ST_OUT = ST_IT0 + QW + 1;
  localparam int unsigned NST    = ST_OUT + 1;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST:0]   en;

  // a stage loads when it is empty or the stage after it loads
  always_comb begin
    en[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[ST_DIF];
  assign out_valid = vld_r[ST_OUT];

  // edge vectors u = a - b and v = b - c
  logic signed [DFW-1:0] u_r [3];
  logic signed [DFW-1:0] v_r [3];

  always_ff @(posedge clk) begin
    if (en[ST_DIF]) begin
      u_r[0] <= DFW'(in_corner_a_x) - DFW'(in_corner_b_x);
      u_r[1] <= DFW'(in_corner_a_y) - DFW'(in_corner_b_y);
      u_r[2] <= DFW'(in_corner_a_z) - DFW'(in_corner_b_z);
      v_r[0] <= DFW'(in_corner_b_x) - DFW'(in_corner_c_x);
      v_r[1] <= DFW'(in_corner_b_y) - DFW'(in_corner_c_y);
      v_r[2] <= DFW'(in_corner_b_z) - DFW'(in_corner_c_z);
    end
  end

  // six cross terms, two per component
  logic signed [PW-1:0] pr_r [6];

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      pr_r[0] <= PW'(u_r[1]) * PW'(v_r[2]);
      pr_r[1] <= PW'(u_r[2]) * PW'(v_r[1]);
      pr_r[2] <= PW'(u_r[2]) * PW'(v_r[0]);
      pr_r[3] <= PW'(u_r[0]) * PW'(v_r[2]);
      pr_r[4] <= PW'(u_r[0]) * PW'(v_r[1]);
      pr_r[5] <= PW'(u_r[1]) * PW'(v_r[0]);
    end
  end

  // cross product, kept as sign and magnitude
  logic signed [NW-1:0] n_cmb [3];
  logic [MW-1:0]        m_r   [3];
  logic [2:0]           neg3_r;
  logic                 dg3_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n_cmb[c] = NW'(pr_r[2*c]) - NW'(pr_r[2*c+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CRS]) begin
      for (int c = 0; c < 3; c++) begin
        m_r[c]    <= n_cmb[c][NW-1] ? MW'(-n_cmb[c]) : MW'(n_cmb[c]);
        neg3_r[c] <= n_cmb[c][NW-1];
      end
      dg3_r <= (n_cmb[0] == '0) && (n_cmb[1] == '0) && (n_cmb[2] == '0);
    end
  end

  // squares split into half-width partial products
  logic [2*HH-1:0]  pp_hh_r [3];
  logic [HH+HL-1:0] pp_hl_r [3];
  logic [2*HL-1:0]  pp_ll_r [3];
  logic [2:0]       neg4_r;
  logic             dg4_r;

  always_ff @(posedge clk) begin
    if (en[ST_PP]) begin
      for (int c = 0; c < 3; c++) begin
        pp_hh_r[c] <= (2*HH)'(m_r[c][MW-1:HL]) * (2*HH)'(m_r[c][MW-1:HL]);
        pp_hl_r[c] <= (HH+HL)'(m_r[c][MW-1:HL]) * (HH+HL)'(m_r[c][HL-1:0]);
        pp_ll_r[c] <= (2*HL)'(m_r[c][HL-1:0]) * (2*HL)'(m_r[c][HL-1:0]);
      end
      neg4_r <= neg3_r;
      dg4_r  <= dg3_r;
    end
  end

  logic [SQW-1:0] sq_r [3];
  logic [2:0]     neg5_r;
  logic           dg5_r;

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= (SQW'(pp_hh_r[c]) << (2*HL)) + (SQW'(pp_hl_r[c]) << (HL+1))
                 + SQW'(pp_ll_r[c]);
      end
      neg5_r <= neg4_r;
      dg5_r  <= dg4_r;
    end
  end

  // quotient pipeline: q = largest value with q^2 * s <= m^2 * 2^(2F)
  // rem holds m^2 * 2^(2F) - q^2 * s, acc holds q * s
  logic [DW-1:0] it_rem_r [QW+1][3];
  logic [DW-1:0] it_acc_r [QW+1][3];
  logic [QW-1:0] it_q_r   [QW+1][3];
  logic [SW-1:0] it_s_r   [QW+1];
  logic [2:0]    it_neg_r [QW+1];
  logic          it_dg_r  [QW+1];

  always_ff @(posedge clk) begin
    if (en[ST_IT0]) begin
      for (int c = 0; c < 3; c++) begin
        it_rem_r[0][c] <= DW'(sq_r[c]) << (2*F);
        it_acc_r[0][c] <= '0;
        it_q_r[0][c]   <= '0;
      end
      it_s_r[0]   <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      it_neg_r[0] <= neg5_r;
      it_dg_r[0]  <= dg5_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_iter
    localparam int unsigned K = F - j;  // result bit decided here

    logic [DW-1:0] trial [3];
    logic [2:0]    fits;

    // (q + 2^K)^2 s - q^2 s = q s 2^(K+1) + s 2^(2K)
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = (it_acc_r[j][c] << (K+1)) + (DW'(it_s_r[j]) << (2*K));
        fits[c]  = it_rem_r[j][c] >= trial[c];
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_IT0+j+1]) begin
        for (int c = 0; c < 3; c++) begin
          if (fits[c]) begin
            it_rem_r[j+1][c] <= it_rem_r[j][c] - trial[c];
            it_acc_r[j+1][c] <= it_acc_r[j][c] + (DW'(it_s_r[j]) << K);
            it_q_r[j+1][c]   <= it_q_r[j][c] | (QW'(1) << K);
          end else begin
            it_rem_r[j+1][c] <= it_rem_r[j][c];
            it_acc_r[j+1][c] <= it_acc_r[j][c];
            it_q_r[j+1][c]   <= it_q_r[j][c];
          end
        end
        it_s_r[j+1]   <= it_s_r[j];
        it_neg_r[j+1] <= it_neg_r[j];
        it_dg_r[j+1]  <= it_dg_r[j];
      end
    end
  end

  // output register: apply sign, force zero for a flat triangle
  logic signed [OW-1:0] unit_nxt [3];
  logic signed [OW-1:0] unit_r   [3];
  logic                 dg_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (it_dg_r[QW]) begin
        unit_nxt[c] = '0;
      end else if (it_neg_r[QW][c]) begin
        unit_nxt[c] = -$signed(OW'(it_q_r[QW][c]));
      end else begin
        unit_nxt[c] = $signed(OW'(it_q_r[QW][c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int c = 0; c < 3; c++) begin
        unit_r[c] <= unit_nxt[c];
      end
      dg_r <= it_dg_r[QW];
    end
  end

  assign out_unit_x     = unit_r[0];
  assign out_unit_y     = unit_r[1];
  assign out_unit_z     = unit_r[2];
  assign out_degenerate = dg_r;

endmodule
